[hw/rtl/serial_rx_ring_word_reader_defines.svh]
// ----------------------------------------------------------------------------
// serial_rx_ring_word_reader assertion macros
// shared concurrent assertion forms for the ring reader rtl
// ----------------------------------------------------------------------------
`ifndef SERIAL_RX_RING_WORD_READER_DEFINES_SVH
`define SERIAL_RX_RING_WORD_READER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SRRWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SRRWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/srrwr_pkg.sv]
// ----------------------------------------------------------------------------
// srrwr_pkg
// constants and result codes for the serial receive ring word reader
// ----------------------------------------------------------------------------
package srrwr_pkg;

  localparam int BUFFER_BYTES   = 4096;
  localparam int MAX_DATA_WORDS = 63;

  localparam int PTR_W    = $clog2(BUFFER_BYTES);
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 16;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int LANE_W   = 2;
  localparam int CAP_BYTES = 4 * MAX_DATA_WORDS;
  localparam int GRANT_W  = $clog2(CAP_BYTES + 1);

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [GRANT_W-1:0] grant_t;
  typedef logic [KIND_W-1:0]  kind_t;

  localparam logic MODE_RX   = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam kind_t KIND_STORED  = 2'd0;
  localparam kind_t KIND_DROPPED = 2'd1;
  localparam kind_t KIND_LENGTH  = 2'd2;
  localparam kind_t KIND_DATA    = 2'd3;

endpackage

[hw/rtl/srrwr_ram.sv]
// ----------------------------------------------------------------------------
// srrwr_ram
// single-port synchronous ram, one write or one read per cycle, registered read
// ----------------------------------------------------------------------------
module srrwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/serial_rx_ring_word_reader.sv]
// ----------------------------------------------------------------------------
// serial_rx_ring_word_reader
// byte ring for serial receive with a reader that packs bytes into 32-bit words
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                              | handshake
//  --------+-----------+--------------------------------------+----------------
//  in_     | input     | mode, rx_byte, read_count            | valid / ready
//  out_    | output    | kind, data, last                     | valid / ready
//
//  a received byte is written into the ring ram unless the ring is full, and gives one status item
//  a read emits the length word first, then for each byte a ram address and the
//  registered ram data, and a packed word after every fourth byte and after the
//  last byte; the single ram port sets the pace of these fetches
//  reset clears the pointers and the control state; the ring ram is not cleared
//  a stalled out_ready holds the result register; the read sequencer packs at
//  most one more word and then waits to emit it; input is taken only while
//  the sequencer is idle and the result register can load
//
module serial_rx_ring_word_reader (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [7:0]                in_rx_byte,
  input  logic [15:0]               in_read_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [31:0]               out_data,
  output logic                      out_last
);
  import srrwr_pkg::*;
  `include "serial_rx_ring_word_reader_defines.svh"

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  ptr_t              wp_r, wp_nxt;
  ptr_t              rp_r, rp_nxt;
  grant_t            rem_r, rem_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic [DATA_W-1:0] word_r, word_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we;
  ptr_t              ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  logic              out_free;
  logic              in_accept;
  ptr_t              wp_inc;
  ptr_t              fill;
  logic [CNT_W-1:0]  fill_ext;
  logic [CNT_W-1:0]  req_clip;
  grant_t            grant;

  // ring storage, one port shared by byte writes and reader fetches
  srrwr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_rx_byte),
    .rdata (ram_rdata)
  );

  // result register loads when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_accept = in_valid && in_ready;

  // ring occupancy and the granted read length
  assign wp_inc   = wp_r + ptr_t'(1);
  assign fill     = wp_r - rp_r;
  assign fill_ext = CNT_W'(fill);

  always_comb begin
    req_clip = in_read_count;
    if (req_clip > fill_ext) begin
      req_clip = fill_ext;
    end
    if (req_clip > CNT_W'(CAP_BYTES)) begin
      req_clip = CNT_W'(CAP_BYTES);
    end
    grant = req_clip[GRANT_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    rem_nxt       = rem_r;
    lane_nxt      = lane_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_addr      = rp_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_valid_nxt = 1'b1;
          if (in_mode == MODE_RX) begin
            // store unless one slot short of wrapping onto the read pointer
            ram_addr     = wp_r;
            out_data_nxt = '0;
            out_last_nxt = 1'b1;
            if (wp_inc != rp_r) begin
              ram_we       = 1'b1;
              wp_nxt       = wp_inc;
              out_kind_nxt = KIND_STORED;
            end else begin
              out_kind_nxt = KIND_DROPPED;
            end
          end else begin
            // length word first, then fetch the granted bytes
            out_kind_nxt = KIND_LENGTH;
            out_data_nxt = DATA_W'(grant);
            out_last_nxt = (grant == '0);
            rem_nxt      = grant;
            lane_nxt     = '0;
            word_nxt     = '0;
            if (grant != '0) begin
              state_nxt = S_ADDR;
            end
          end
        end
      end
      S_ADDR: begin
        // read address goes out, data comes back next cycle
        ram_addr  = rp_r;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        word_nxt[{lane_r, 3'b000} +: BYTE_W] = ram_rdata;
        rp_nxt   = rp_r + ptr_t'(1);
        rem_nxt  = rem_r - grant_t'(1);
        lane_nxt = lane_r + LANE_W'(1);
        if ((lane_r == LANE_W'(3)) || (rem_r == grant_t'(1))) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_EMIT: begin
        // packed word waits here for room in the result register
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DATA;
          out_data_nxt  = word_r;
          out_last_nxt  = (rem_r == '0);
          word_nxt      = '0;
          lane_nxt      = '0;
          state_nxt     = (rem_r == '0) ? S_IDLE : S_ADDR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and sequencer working registers
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    lane_r     <= lane_nxt;
    word_r     <= word_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  // a fetch is only started while bytes remain
  `SRRWR_ASSERT_NOW(a_fetch_has_bytes, state_r == S_ADDR, rem_r != '0, "fetch with no bytes left")
  // the read pointer moves only when a fetched byte is packed
  `SRRWR_ASSERT_NEXT(a_rp_moves_on_data, state_r != S_DATA, $stable(rp_r), "read pointer moved")
  // the write pointer moves only on an item taken while idle
  `SRRWR_ASSERT_NEXT(a_wp_moves_idle, state_r != S_IDLE, $stable(wp_r), "write pointer moved")
  // the final word of a read returns the sequencer to idle
  `SRRWR_ASSERT_NEXT(a_last_word_idle, (state_r == S_EMIT) && out_free && (rem_r == '0), (state_r == S_IDLE) && out_valid_r && out_last_r, "read did not end")

endmodule

[verif/tb_serial_rx_ring_word_reader.sv]
// ----------------------------------------------------------------------------
// tb_serial_rx_ring_word_reader
// self-checking bench for the serial receive ring with its word-packing reader
// ----------------------------------------------------------------------------
//
//  received bytes and read requests are queued up front and pushed through a
//  valid/ready driver; every accepted item runs through a local ring predictor
//  that queues the status, length and data words it should cause, and a
//  monitor checks each result against the oldest one waiting
//  the run covers a short directed list, three random phases with different
//  idle patterns on both sides, a long receiver hold-off that backs up the
//  input, and reads clipped to the word limit that drain the ring
//
module tb_serial_rx_ring_word_reader;
  timeunit 1ns;
  timeprecision 1ps;

  import srrwr_pkg::*;

  localparam int QUIET_LIMIT     = 5000;  // cycles with no item moving on either side
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall to back the block up
  localparam int DRAIN_CYCLES    = 40;    // settle time after the last result
  localparam int RANDOM_PER_PHASE = 140;

  // one input item, fields as the ports carry them
  typedef struct {
    logic        mode;
    logic [7:0]  rx_byte;
    logic [15:0] read_count;
  } rx_item_t;

  // one result item
  typedef struct {
    kind_t       kind;
    logic [31:0] data;
    logic        last;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = MODE_RX;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [15:0] in_read_count = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_data;
  logic        out_last;

  serial_rx_ring_word_reader i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_rx_byte    (in_rx_byte),
    .in_read_count (in_read_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data      (out_data),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // items waiting to be offered, and results still owed by the block
  rx_item_t     rx_items_q[$];
  ring_result_t expected_results_q[$];

  // predictor copy of the ring
  logic [7:0] ring_mem [BUFFER_BYTES];
  ptr_t       wr_ptr = '0;
  ptr_t       rd_ptr = '0;

  // idle pattern, switched by the stimulus process between phases
  int send_idle_pct = 28;
  int recv_idle_pct = 50;
  logic hold_off_go = 1'b0;

  // handshake seen at the last rising edge, used by the driver
  bit in_took;

  // bookkeeping for the summary
  int errors;
  int items_taken, bytes_stored, bytes_dropped, reads_taken, data_words;
  int input_blocked_cycles;

  // ring predictor: works out every result one accepted item causes
  task automatic predict_ring_results(input rx_item_t it);
    ptr_t        nxt;
    int          fill;
    int          grant;
    int          words;
    logic [31:0] word;
    if (it.mode == MODE_RX) begin
      nxt = wr_ptr + 1'b1;
      // one slot always stays free, so next == read pointer means full
      if (nxt != rd_ptr) begin
        ring_mem[wr_ptr] = it.rx_byte;
        wr_ptr = nxt;
        expected_results_q.push_back(ring_result_t'{KIND_STORED, 32'd0, 1'b1});
        bytes_stored++;
      end else begin
        expected_results_q.push_back(ring_result_t'{KIND_DROPPED, 32'd0, 1'b1});
        bytes_dropped++;
      end
    end else begin
      fill  = int'(ptr_t'(wr_ptr - rd_ptr));
      grant = int'(it.read_count);
      if (grant > fill) grant = fill;
      if (grant > CAP_BYTES) grant = CAP_BYTES;
      words = (grant + 3) / 4;
      // length word closes the item only when nothing follows
      expected_results_q.push_back(ring_result_t'{KIND_LENGTH, 32'(grant), words == 0});
      for (int w = 0; w < words; w++) begin
        word = '0;
        for (int b = 0; b < 4; b++) begin
          if (w * 4 + b < grant) begin
            word[8*b +: 8] = ring_mem[rd_ptr];
            rd_ptr++;
          end
        end
        // lanes past the grant stay zero
        expected_results_q.push_back(ring_result_t'{KIND_DATA, word, w == words - 1});
      end
      reads_taken++;
      data_words += words;
    end
  endtask

  task automatic queue_rx_byte(input logic [7:0] value);
    rx_items_q.push_back(rx_item_t'{MODE_RX, value, 16'(value) ^ 16'hFFFF});
  endtask

  task automatic queue_read(input logic [15:0] count);
    rx_items_q.push_back(rx_item_t'{MODE_READ, count[7:0] ^ 8'h5A, count});
  endtask

  // random mix: mostly bytes, reads with mostly small counts, now and then
  // a count across the whole 16-bit range
  task automatic queue_random_items(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 62) begin
        queue_rx_byte(8'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 10)      queue_read(16'd0);
        else if (pick < 70) queue_read(16'($urandom_range(12, 1)));
        else if (pick < 90) queue_read(16'($urandom_range(300, 13)));
        else                queue_read(16'($urandom));
      end
    end
  endtask

  task automatic wait_items_offered();
    while (rx_items_q.size() != 0) @(posedge clk);
  endtask

  // driver: new item at the falling edge once the previous one was taken
  always @(negedge clk) begin : drive_rx
    rx_item_t it;
    if (rst_n && (!in_valid || in_took)) begin
      if (rx_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = rx_items_q.pop_front();
        in_valid      <= 1'b1;
        in_mode       <= it.mode;
        in_rx_byte    <= it.rx_byte;
        in_read_count <= it.read_count;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off counted here
  always @(negedge clk) begin : drive_ready
    int  hold_left;
    bit  hold_done;
    if (rst_n) begin
      if (hold_off_go && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor: predict on accepted input, check accepted results
  always @(posedge clk) begin : watch_ports
    rx_item_t     it;
    ring_result_t want;
    bit           bad;
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      in_took = in_valid && in_ready;
      if (in_took) begin
        it.mode       = in_mode;
        it.rx_byte    = in_rx_byte;
        it.read_count = in_read_count;
        items_taken++;
        predict_ring_results(it);
      end
      if (in_valid && !in_ready) input_blocked_cycles++;
      if (out_valid && out_ready) begin
        if (expected_results_q.size() == 0) begin
          $display("%0t: result with nothing expected: kind %0d data %h last %0b",
                   $time, out_kind, out_data, out_last);
          errors++;
        end else begin
          want = expected_results_q.pop_front();
          bad  = 1'b0;
          if (out_kind !== want.kind) bad = 1'b1;
          if (out_data !== want.data) bad = 1'b1;
          if (out_last !== want.last) bad = 1'b1;
          if (bad) begin
            $display("%0t: mismatch: expected kind %0d data %h last %0b, got kind %0d data %h last %0b",
                     $time, want.kind, want.data, want.last, out_kind, out_data, out_last);
            errors++;
          end
        end
      end
    end
  end

  // watchdog: too long with nothing moving on either channel
  always @(posedge clk) begin : quiet_watch
    int quiet;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results still owed",
               $time, quiet, expected_results_q.size());
      $display("tb_serial_rx_ring_word_reader NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty reads, byte extremes, zero count on a filled ring,
    // partial last words, a read clipped to the fill level
    queue_read(16'h0000);
    queue_read(16'hFFFF);
    queue_rx_byte(8'h00);
    queue_rx_byte(8'hFF);
    queue_rx_byte(8'hA5);
    queue_rx_byte(8'h5A);
    queue_rx_byte(8'h01);
    queue_read(16'h0000);
    queue_read(16'h0001);
    queue_read(16'h0002);
    queue_rx_byte(8'h80);
    queue_rx_byte(8'h7F);
    queue_rx_byte(8'h3C);
    queue_read(16'h0003);
    queue_rx_byte(8'hC3);
    queue_rx_byte(8'h99);
    queue_rx_byte(8'h66);
    queue_read(16'h8000);
    queue_read(16'h0005);
    queue_rx_byte(8'h12);
    queue_read(16'h7FFF);

    // phase one: sender idles a little, receiver a lot
    queue_random_items(RANDOM_PER_PHASE);
    wait_items_offered();

    // phase two: the other way round
    send_idle_pct = 50;
    recv_idle_pct = 28;
    queue_random_items(RANDOM_PER_PHASE);
    wait_items_offered();

    // phase three: no idling, and a long receiver stall while the sender
    // keeps offering so the block backs up into its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_items(RANDOM_PER_PHASE);
    hold_off_go = 1'b1;

    // drain what the ring holds in reads clipped to the word limit
    for (int i = 0; i < 2; i++) queue_read(16'hFFFF);
    queue_random_items(40);
    wait_items_offered();

    // last item taken, then every owed result back, then a short settle
    while (in_valid) @(posedge clk);
    while (expected_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d bytes stored, %0d dropped on a full ring, %0d reads",
             items_taken, bytes_stored, bytes_dropped, reads_taken);
    $display("%0d packed data words checked, input held off for %0d cycles",
             data_words, input_blocked_cycles);
    if (errors == 0) begin
      $display("tb_serial_rx_ring_word_reader OK");
    end else begin
      $display("tb_serial_rx_ring_word_reader NOT OK");
    end
    $finish;
  end

endmodule
